// File: rtl/core/epipolar_sampson_inlier_test_core_assert.svh
// Assertion macros used by the Sampson inlier test core top level.
// Included by that module, which checks its own pipeline behavior.
`ifndef EPIPOLAR_SAMPSON_INLIER_TEST_CORE_ASSERT_SVH
`define EPIPOLAR_SAMPSON_INLIER_TEST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ESIT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define ESIT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define ESIT_ASSERT(lbl, clk, rst_n, prop, msg)
`define ESIT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// File: rtl/core/esit_pkg.sv
// Shared constants and types of the Sampson inlier test core.
// No dependencies; used by esit_sq, the top level and the testbench.
`timescale 1ns / 1ps

package esit_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF  = 18;
  localparam int THR_W           = 32;
  localparam int THR_FRAC        = 24;
  localparam int TAG_W           = 16;
  localparam int CFG_AW          = 2;
  localparam int OUT_DW          = ((1 + TAG_W + 7) / 8) * 8;

  typedef enum logic [CFG_AW-1:0] {
    CFG_F_TOP     = 2'd0,
    CFG_F_MIDDLE  = 2'd1,
    CFG_F_BOTTOM  = 2'd2,
    CFG_THRESHOLD = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic ce_part;
    logic ce_sum;
  } sq_ctl_t;

endpackage

// File: rtl/core/esit_sq.sv
// Two-stage pipelined squarer for an unsigned magnitude, split into halves.
// Depends on esit_pkg for the stage enable struct.
`timescale 1ns / 1ps

module esit_sq #(
  parameter int W = 36
) (
  input  logic                      clk,
  input  esit_pkg::sq_ctl_t         ctl,
  input  logic [W-1:0]              mag,
  output logic [4*((W+1)/2)-1:0]    sq
);
  import esit_pkg::*;

  localparam int H = (W + 1) / 2;

  logic [2*H-1:0] mp;
  logic [H-1:0]   lo;
  logic [H-1:0]   hi;
  logic [2*H-1:0] ll_nxt, lh_nxt, hh_nxt;
  logic [2*H-1:0] ll_r, lh_r, hh_r;
  logic [4*H-1:0] sq_nxt, sq_r;

  always_comb begin
    mp     = (2*H)'(mag);
    lo     = mp[H-1:0];
    hi     = mp[2*H-1:H];
    ll_nxt = (2*H)'(lo) * (2*H)'(lo);
    lh_nxt = (2*H)'(lo) * (2*H)'(hi);
    hh_nxt = (2*H)'(hi) * (2*H)'(hi);
    // cross term appears twice in the square
    sq_nxt = (4*H)'(ll_r) + ((4*H)'(lh_r) << (H + 1)) + ((4*H)'(hh_r) << (2 * H));
  end

  always_ff @(posedge clk) begin
    if (ctl.ce_part) begin
      ll_r <= ll_nxt;
      lh_r <= lh_nxt;
      hh_r <= hh_nxt;
    end
    if (ctl.ce_sum) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq = sq_r;

endmodule

// File: rtl/core/epipolar_sampson_inlier_test_core.sv
// Sampson epipolar inlier test: top level with configuration and pipeline.
// Depends on esit_pkg, esit_sq and the assertion macro header.
//
// One point correspondence enters per cycle unless all stages are full and
// stalled; a stalled output holds its transaction while bubbles further up are
// still filled, so input is taken whenever any stage ahead can move. The nine
// register stages are the epipolar line products, the line sums, the numerator
// terms and line magnitudes, two stages of split squarers, the denominator sum,
// the threshold products, their sum, and the final compare into the output
// register. The user must write matrix rows and the threshold through the cfg
// port only while no transaction is in flight; the block does not enforce this.
`timescale 1ns / 1ps

module epipolar_sampson_inlier_test_core #(
  parameter int COORD_WIDTH = esit_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = esit_pkg::COEF_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // first_x, first_y, second_x, second_y, match_tag (low bit up), zero padded
  input  logic [((4*COORD_WIDTH+esit_pkg::TAG_W+7)/8)*8-1:0] in_tdata,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic in_tlast,
  // is_inlier, result_tag (low bit up), zero padded
  output logic [esit_pkg::OUT_DW-1:0] out_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  output logic out_tlast,
  input  logic cfg_we,
  input  logic [esit_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [((3*COEF_WIDTH > esit_pkg::THR_W) ? 3*COEF_WIDTH : esit_pkg::THR_W)-1:0]
               cfg_wdata
);
  import esit_pkg::*;

  `include "epipolar_sampson_inlier_test_core_assert.svh"

  localparam int CW   = COORD_WIDTH;
  localparam int KW   = COEF_WIDTH;
  localparam int CF   = CW - 4;
  localparam int PW   = CW + KW;
  localparam int AW   = PW + 2;
  localparam int NTW  = CW + AW;
  localparam int NW   = NTW + 2;
  localparam int SH   = (AW + 1) / 2;
  localparam int SQW  = 4 * SH;
  localparam int DW   = SQW + 2;
  localparam int NH   = (NW + 1) / 2;
  localparam int NSQW = 4 * NH;
  localparam int DH   = (DW + 1) / 2;
  localparam int TPW  = THR_W + DH;
  localparam int RHSW = TPW + DH + 1;
  localparam int CMPL = NSQW + THR_FRAC;
  localparam int CMPR = RHSW + 2 * CF;
  localparam int CMPW = (CMPL > CMPR) ? CMPL : CMPR;
  localparam int NST  = 9;

  // configuration
  logic [3*KW-1:0]  row_r [3];
  logic [THR_W-1:0] thr_r;
  logic signed [KW-1:0] f [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= '0;
      row_r[1] <= '0;
      row_r[2] <= '0;
      thr_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_F_TOP:     row_r[0] <= cfg_wdata[3*KW-1:0];
        CFG_F_MIDDLE:  row_r[1] <= cfg_wdata[3*KW-1:0];
        CFG_F_BOTTOM:  row_r[2] <= cfg_wdata[3*KW-1:0];
        CFG_THRESHOLD: thr_r    <= cfg_wdata[THR_W-1:0];
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        f[i][j] = $signed(row_r[i][j*KW +: KW]);
      end
    end
  end

  // pipeline control
  logic [NST-1:0] v_r, v_nxt, v_src;
  logic [NST:0]   ce;
  logic [NST-1:0][TAG_W-1:0] tag_r, tag_src;
  logic [NST-1:0] last_r, last_src;

  always_comb begin
    ce[NST] = out_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      ce[k] = !v_r[k] || ce[k+1];
    end
    v_src    = {v_r[NST-2:0], in_tvalid};
    tag_src  = {tag_r[NST-2:0], in_tdata[4*CW +: TAG_W]};
    last_src = {last_r[NST-2:0], in_tlast};
    for (int k = 0; k < NST; k++) begin
      v_nxt[k] = ce[k] ? v_src[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (ce[k]) begin
        tag_r[k]  <= tag_src[k];
        last_r[k] <= last_src[k];
      end
    end
  end

  assign in_tready = ce[0];

  // stage 0: matrix by coordinate products
  logic signed [CW-1:0] in_fx, in_fy, in_sx, in_sy;
  logic signed [PW-1:0] pax_nxt [3], pay_nxt [3], pbx_nxt [2], pby_nxt [2];
  logic signed [PW-1:0] pax_r [3], pay_r [3], pbx_r [2], pby_r [2];
  logic signed [CW-1:0] sx0_r, sy0_r;

  always_comb begin
    in_fx = $signed(in_tdata[CW-1:0]);
    in_fy = $signed(in_tdata[2*CW-1:CW]);
    in_sx = $signed(in_tdata[3*CW-1:2*CW]);
    in_sy = $signed(in_tdata[4*CW-1:3*CW]);
    for (int i = 0; i < 3; i++) begin
      pax_nxt[i] = PW'(f[i][0]) * PW'(in_fx);
      pay_nxt[i] = PW'(f[i][1]) * PW'(in_fy);
    end
    for (int i = 0; i < 2; i++) begin
      pbx_nxt[i] = PW'(f[0][i]) * PW'(in_sx);
      pby_nxt[i] = PW'(f[1][i]) * PW'(in_sy);
    end
  end

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      pax_r <= pax_nxt;
      pay_r <= pay_nxt;
      pbx_r <= pbx_nxt;
      pby_r <= pby_nxt;
      sx0_r <= in_sx;
      sy0_r <= in_sy;
    end
  end

  // stage 1: epipolar lines
  logic signed [AW-1:0] a_nxt [3], b_nxt [2];
  logic signed [AW-1:0] a1_r [3], b1_r [2];
  logic signed [CW-1:0] sx1_r, sy1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_nxt[i] = AW'(pax_r[i]) + AW'(pay_r[i]) + (AW'(f[i][2]) <<< CF);
    end
    for (int i = 0; i < 2; i++) begin
      b_nxt[i] = AW'(pbx_r[i]) + AW'(pby_r[i]) + (AW'(f[2][i]) <<< CF);
    end
  end

  always_ff @(posedge clk) begin
    if (ce[1]) begin
      a1_r  <= a_nxt;
      b1_r  <= b_nxt;
      sx1_r <= sx0_r;
      sy1_r <= sy0_r;
    end
  end

  // stage 2: numerator terms, line magnitudes
  logic signed [NTW-1:0] n0_nxt, n1_nxt, n0_r, n1_r;
  logic signed [AW-1:0]  a2c_r;
  logic signed [AW-1:0]  am_src [4];
  logic [AW-1:0]         am_nxt [4], am_r [4];

  always_comb begin
    n0_nxt    = NTW'(sx1_r) * NTW'(a1_r[0]);
    n1_nxt    = NTW'(sy1_r) * NTW'(a1_r[1]);
    am_src[0] = a1_r[0];
    am_src[1] = a1_r[1];
    am_src[2] = b1_r[0];
    am_src[3] = b1_r[1];
    for (int k = 0; k < 4; k++) begin
      am_nxt[k] = am_src[k][AW-1] ? $unsigned(-am_src[k]) : $unsigned(am_src[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce[2]) begin
      n0_r  <= n0_nxt;
      n1_r  <= n1_nxt;
      a2c_r <= a1_r[2];
      am_r  <= am_nxt;
    end
  end

  // stages 3 and 4: line term squares
  sq_ctl_t den_ctl;
  logic [SQW-1:0] sq_w [4];

  assign den_ctl = '{ce_part: ce[3], ce_sum: ce[4]};

  for (genvar g = 0; g < 4; g++) begin : g_den_sq
    esit_sq #(.W(AW)) u_sq (
      .clk (clk),
      .ctl (den_ctl),
      .mag (am_r[g]),
      .sq  (sq_w[g])
    );
  end

  // stage 3: numerator
  logic signed [NW-1:0] num_nxt, num3_r;

  assign num_nxt = NW'(n0_r) + NW'(n1_r) + (NW'(a2c_r) <<< CF);

  always_ff @(posedge clk) begin
    if (ce[3]) begin
      num3_r <= num_nxt;
    end
  end

  // stage 4: numerator magnitude
  logic [NW-1:0] mnum_nxt, mnum4_r;

  assign mnum_nxt = num3_r[NW-1] ? $unsigned(-num3_r) : $unsigned(num3_r);

  always_ff @(posedge clk) begin
    if (ce[4]) begin
      mnum4_r <= mnum_nxt;
    end
  end

  // stage 5: denominator; stages 5 and 6: numerator square
  logic [DW-1:0] den_nxt, den5_r;
  sq_ctl_t       num_ctl;
  logic [NSQW-1:0] nsq_w;

  assign den_nxt = DW'(sq_w[0]) + DW'(sq_w[1]) + DW'(sq_w[2]) + DW'(sq_w[3]);
  assign num_ctl = '{ce_part: ce[5], ce_sum: ce[6]};

  always_ff @(posedge clk) begin
    if (ce[5]) begin
      den5_r <= den_nxt;
    end
  end

  esit_sq #(.W(NW)) u_num_sq (
    .clk (clk),
    .ctl (num_ctl),
    .mag (mnum4_r),
    .sq  (nsq_w)
  );

  // stage 6: threshold by denominator halves
  logic [2*DH-1:0] dp;
  logic [TPW-1:0]  tl_nxt, th_nxt, tl6_r, th6_r;
  logic            dz6_r;

  always_comb begin
    dp     = (2*DH)'(den5_r);
    tl_nxt = TPW'(thr_r) * TPW'(dp[DH-1:0]);
    th_nxt = TPW'(thr_r) * TPW'(dp[2*DH-1:DH]);
  end

  always_ff @(posedge clk) begin
    if (ce[6]) begin
      tl6_r <= tl_nxt;
      th6_r <= th_nxt;
      dz6_r <= (den5_r == '0);
    end
  end

  // stage 7: right-hand side
  logic [RHSW-1:0] rhs_nxt, rhs7_r;
  logic [NSQW-1:0] nsq7_r;
  logic            dz7_r;

  assign rhs_nxt = RHSW'(tl6_r) + (RHSW'(th6_r) << DH);

  always_ff @(posedge clk) begin
    if (ce[7]) begin
      rhs7_r <= rhs_nxt;
      nsq7_r <= nsq_w;
      dz7_r  <= dz6_r;
    end
  end

  // stage 8: compare into the output register
  logic [CMPW-1:0] lhs_c, rhs_c;
  logic            inl_nxt, inl8_r;

  always_comb begin
    lhs_c   = CMPW'(nsq7_r) << THR_FRAC;
    rhs_c   = CMPW'(rhs7_r) << (2 * CF);
    inl_nxt = !dz7_r && (lhs_c < rhs_c);
  end

  always_ff @(posedge clk) begin
    if (ce[8]) begin
      inl8_r <= inl_nxt;
    end
  end

  assign out_tvalid = v_r[NST-1];
  assign out_tdata  = OUT_DW'({tag_r[NST-1], inl8_r});
  assign out_tlast  = last_r[NST-1];

  `ESIT_ASSERT(a_ready_when_drained, clk, rst_n, !out_tvalid |-> in_tready, "input stalled with empty output")
  `ESIT_ASSERT_NEXT(a_zero_den_outlier, clk, rst_n, v_r[NST-2] && ce[NST-1] && dz7_r, !out_tdata[0], "zero denominator flagged inlier")
  `ESIT_ASSERT_NEXT(a_stage_hold, clk, rst_n, v_r[NST-2] && !ce[NST-2], v_r[NST-2] && $stable(tag_r[NST-2]), "stalled stage lost its transaction")

endmodule

// File: verif/tb_epipolar_sampson_inlier_test_core.sv
// Self-checking bench for epipolar_sampson_inlier_test_core: directed rows, then random
// matrix/threshold phases, verdicts checked in order vs typed values or a Sampson predictor.
// Depends on esit_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_epipolar_sampson_inlier_test_core;
  import esit_pkg::*;

  localparam int COORD_W   = COORD_WIDTH_DEF;
  localparam int COEF_W    = COEF_WIDTH_DEF;
  localparam int CF        = COORD_W - 4;
  localparam int ROW_W     = 3 * COEF_W;
  localparam int CFG_DW    = (ROW_W > THR_W) ? ROW_W : THR_W;
  localparam int IN_DW     = ((4 * COORD_W + TAG_W + 7) / 8) * 8;
  localparam int COEF_ONE  = 1 << (COEF_W - 2);
  localparam int COEF_MAX  = (1 << (COEF_W - 1)) - 1;
  localparam int COEF_MIN  = -(1 << (COEF_W - 1));
  localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN = -(1 << (COORD_W - 1));
  localparam int PIPE_LAT  = 12;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 130;

  localparam int KEEP               = -1;
  localparam int SET_SHIFT          = 0;
  localparam int SET_SHIFT_ZERO_THR = 1;
  localparam int SET_NO_LINES       = 2;
  localparam int SET_ALL_MIN        = 3;
  localparam int SET_ALL_MAX        = 4;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic [TAG_W-1:0]          tag;
    logic                      last;
  } match_t;

  typedef struct packed {
    logic             inlier;
    logic [TAG_W-1:0] tag;
    logic             last;
  } verdict_t;

  typedef struct packed {
    logic [CFG_DW-1:0] top;
    logic [CFG_DW-1:0] mid;
    logic [CFG_DW-1:0] bot;
    logic [CFG_DW-1:0] thr;
  } setting_t;

  typedef struct {
    int     setting;
    match_t m;
    bit     typed;
    bit     typed_inlier;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_DW-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic in_tlast = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  logic [ROW_W-1:0] f_rows [3] = '{default: '0};
  logic [THR_W-1:0] thr_q824 = '0;
  verdict_t pending[$];
  stim_row_t directed_rows[$];
  setting_t settings [5];
  int errors = 0;
  bit calm = 1'b0;
  int unsigned stall_left = 0;

  epipolar_sampson_inlier_test_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic logic sampson_inlier(input match_t m);
    longint f [3][3];
    longint p1 [3];
    longint p2 [3];
    longint a [3];
    longint b [3];
    longint num;
    logic [255:0] num_m, den, mag, lhs, rhs;
    int i, j;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        f[i][j] = longint'($signed(f_rows[i][j*COEF_W +: COEF_W]));
      end
    end
    p1[0] = longint'($signed(m.x1));
    p1[1] = longint'($signed(m.y1));
    p1[2] = longint'(1) << CF;
    p2[0] = longint'($signed(m.x2));
    p2[1] = longint'($signed(m.y2));
    p2[2] = longint'(1) << CF;
    for (i = 0; i < 3; i++) begin
      a[i] = 0;
      b[i] = 0;
      for (j = 0; j < 3; j++) begin
        a[i] += f[i][j] * p1[j];
        b[i] += f[j][i] * p2[j];
      end
    end
    num = 0;
    for (i = 0; i < 3; i++) num += p2[i] * a[i];
    if (num < 0) num = -num;
    num_m = 256'(num);
    den = '0;
    for (i = 0; i < 2; i++) begin
      mag = 256'((a[i] < 0) ? -a[i] : a[i]);
      den = den + mag * mag;
      mag = 256'((b[i] < 0) ? -b[i] : b[i]);
      den = den + mag * mag;
    end
    lhs = (num_m * num_m) << THR_FRAC;
    rhs = (256'(thr_q824) * den) << (2 * CF);
    return (den != '0) && (lhs < rhs);
  endfunction

  function automatic logic [ROW_W-1:0] pack_row(input int c0, input int c1, input int c2);
    return {c2[COEF_W-1:0], c1[COEF_W-1:0], c0[COEF_W-1:0]};
  endfunction

  function automatic stim_row_t drow(input int setting, input int x1, input int y1,
                                     input int x2, input int y2, input int tag,
                                     input bit last, input bit typed, input bit typed_inlier);
    stim_row_t r;
    r.setting = setting;
    r.m.x1 = x1[COORD_W-1:0];
    r.m.y1 = y1[COORD_W-1:0];
    r.m.x2 = x2[COORD_W-1:0];
    r.m.y2 = y2[COORD_W-1:0];
    r.m.tag = tag[TAG_W-1:0];
    r.m.last = last;
    r.typed = typed;
    r.typed_inlier = typed_inlier;
    return r;
  endfunction

  function automatic void add_row(input stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic int extreme_coef();
    case ($urandom_range(0, 3))
      0: return COEF_MIN;
      1: return COEF_MAX;
      2: return 0;
      default: return int'($signed(COEF_W'($urandom)));
    endcase
  endfunction

  function automatic match_t random_match(input bit aligned);
    match_t m;
    int w, y2;
    m.x1 = COORD_W'($urandom);
    m.y1 = COORD_W'($urandom);
    m.x2 = COORD_W'($urandom);
    m.y2 = COORD_W'($urandom);
    m.tag = TAG_W'($urandom);
    m.last = ($urandom_range(0, 7) == 0);
    // keep the second point close to the horizontal epipolar line
    if (aligned && $urandom_range(0, 4) != 0) begin
      w = $urandom_range(0, 256);
      y2 = int'(m.y1) + int'($urandom_range(0, 2 * w)) - w;
      if (y2 > COORD_MAX) y2 = COORD_MAX;
      if (y2 < COORD_MIN) y2 = COORD_MIN;
      m.y2 = y2[COORD_W-1:0];
    end
    return m;
  endfunction

  task automatic flag_error(input string what, input longint expv, input longint actv);
    errors++;
    if (errors <= 10) begin
      $display("mismatch %s: expected %0h got %0h at %0t", what, expv, actv, $realtime);
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_F_TOP:     f_rows[0] = val[ROW_W-1:0];
      CFG_F_MIDDLE:  f_rows[1] = val[ROW_W-1:0];
      CFG_F_BOTTOM:  f_rows[2] = val[ROW_W-1:0];
      CFG_THRESHOLD: thr_q824 = val[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input setting_t s);
    write_reg(CFG_F_TOP, s.top);
    write_reg(CFG_F_MIDDLE, s.mid);
    write_reg(CFG_F_BOTTOM, s.bot);
    write_reg(CFG_THRESHOLD, s.thr);
    cfg_we <= 1'b0;
  endtask

  // drain the pipeline before touching the registers
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic send_match(input match_t m, input bit typed, input bit typed_inlier);
    verdict_t v;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DW'({m.tag, m.y2, m.x2, m.y1, m.x1});
    in_tlast <= m.last;
    v.inlier = typed ? typed_inlier : sampson_inlier(m);
    v.tag = m.tag;
    v.last = m.last;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    pending.insert(pending.size(), v);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(negedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending.size() == 0) begin
        flag_error("transaction with nothing pending", 0, longint'(out_tdata));
      end else begin
        want = pending.pop_front();
        if (out_tdata[0] !== want.inlier) begin
          flag_error("is_inlier", longint'(want.inlier), longint'(out_tdata[0]));
        end
        if (out_tdata[TAG_W:1] !== want.tag) begin
          flag_error("result_tag", longint'(want.tag), longint'(out_tdata[TAG_W:1]));
        end
        if (out_tlast !== want.last) begin
          flag_error("result_last", longint'(want.last), longint'(out_tlast));
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    setting_t s;
    int ph, n, kind, sc;
    bit aligned;

    settings[SET_SHIFT].top = '0;
    settings[SET_SHIFT].mid = pack_row(0, 0, -COEF_ONE);
    settings[SET_SHIFT].bot = pack_row(0, COEF_ONE, 0);
    settings[SET_SHIFT].thr = {{(CFG_DW-THR_W){1'b1}}, 32'hFFFF_FFFF};
    settings[SET_SHIFT_ZERO_THR] = settings[SET_SHIFT];
    settings[SET_SHIFT_ZERO_THR].thr = '0;
    settings[SET_NO_LINES].top = '0;
    settings[SET_NO_LINES].mid = '0;
    settings[SET_NO_LINES].bot = pack_row(0, 0, COEF_ONE);
    settings[SET_NO_LINES].thr = {{(CFG_DW-THR_W){1'b1}}, 32'hFFFF_FFFF};
    settings[SET_ALL_MIN].top = pack_row(COEF_MIN, COEF_MIN, COEF_MIN);
    settings[SET_ALL_MIN].mid = settings[SET_ALL_MIN].top;
    settings[SET_ALL_MIN].bot = settings[SET_ALL_MIN].top;
    settings[SET_ALL_MIN].thr = CFG_DW'(32'hFFFF_FFFF);
    settings[SET_ALL_MAX].top = pack_row(COEF_MAX, COEF_MAX, COEF_MAX);
    settings[SET_ALL_MAX].mid = settings[SET_ALL_MAX].top;
    settings[SET_ALL_MAX].bot = settings[SET_ALL_MAX].top;
    settings[SET_ALL_MAX].thr = {{(CFG_DW-THR_W){1'b1}}, 32'h1};

    // registers still at reset: zero matrix, every match is an outlier
    add_row(drow(KEEP, 0, 0, 0, 0, 16'h0000, 0, 1, 0));
    add_row(drow(KEEP, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                 16'hFFFF, 1, 1, 0));
    add_row(drow(KEEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                 16'h5555, 0, 1, 0));
    // horizontal shift: equal y gives a zero numerator
    add_row(drow(SET_SHIFT, 0, 0, 0, 0, 16'hAAAA, 0, 1, 1));
    add_row(drow(KEEP, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                 16'h0001, 1, 1, 1));
    add_row(drow(KEEP, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX,
                 16'h8000, 0, 1, 1));
    add_row(drow(KEEP, 0, 100, 0, -100, 16'h1234, 0, 0, 0));
    add_row(drow(KEEP, 1, 2, 3, 4, 16'h4321, 1, 0, 0));
    // zero threshold
    add_row(drow(SET_SHIFT_ZERO_THR, 0, 0, 0, 0, 16'h0F0F, 0, 1, 0));
    add_row(drow(KEEP, 5, 5, 5, 5, 16'hF0F0, 1, 1, 0));
    // only the corner entry set: both lines vanish, zero denominator
    add_row(drow(SET_NO_LINES, 0, 0, 0, 0, 16'h0002, 0, 1, 0));
    add_row(drow(KEEP, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                 16'h0003, 0, 1, 0));
    add_row(drow(KEEP, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                 16'h0004, 1, 1, 0));
    add_row(drow(SET_ALL_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                 16'h0005, 0, 0, 0));
    add_row(drow(KEEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                 16'h0006, 0, 0, 0));
    add_row(drow(KEEP, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                 16'h0007, 0, 0, 0));
    add_row(drow(KEEP, 0, 0, 0, 0, 16'h0008, 1, 0, 0));
    add_row(drow(SET_ALL_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                 16'h0009, 0, 0, 0));
    add_row(drow(KEEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                 16'h000A, 0, 0, 0));
    add_row(drow(KEEP, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                 16'h000B, 0, 0, 0));
    add_row(drow(KEEP, -1, 1, 1, -1, 16'h000C, 1, 0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].setting != KEEP) begin
        settle();
        load_setting(settings[directed_rows[k].setting]);
      end
      send_match(directed_rows[k].m, directed_rows[k].typed, directed_rows[k].typed_inlier);
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      calm = (ph == RAND_PHASES - 1) || ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 4);
      aligned = (kind >= 2 && kind != 3);
      case (kind)
        3: begin
          s.top = pack_row(extreme_coef(), extreme_coef(), extreme_coef());
          s.mid = pack_row(extreme_coef(), extreme_coef(), extreme_coef());
          s.bot = pack_row(extreme_coef(), extreme_coef(), extreme_coef());
        end
        2, 4: begin
          sc = $urandom_range(1, COEF_MAX);
          if ($urandom_range(0, 1) == 1) sc = -sc;
          s.top = pack_row(extreme_coef() >>> $urandom_range(8, 17), 0, 0);
          s.mid = pack_row(0, 0, -sc);
          s.bot = pack_row(0, sc, 0);
        end
        default: begin
          s.top = CFG_DW'({$urandom, $urandom});
          s.mid = CFG_DW'({$urandom, $urandom});
          s.bot = CFG_DW'({$urandom, $urandom});
        end
      endcase
      case ($urandom_range(0, 5))
        0: s.thr = CFG_DW'({$urandom, 32'h0});
        1: s.thr = CFG_DW'({$urandom, 32'hFFFF_FFFF});
        default: s.thr = CFG_DW'({$urandom, 32'($urandom >> $urandom_range(0, 31))});
      endcase
      load_setting(s);
      for (n = 0; n < ITEMS_PER_PHASE; n++) send_match(random_match(aligned), 0, 0);
    end

    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/esit_pkg.sv
rtl/core/esit_sq.sv
rtl/core/epipolar_sampson_inlier_test_core.sv
verif/tb_epipolar_sampson_inlier_test_core.sv
